// File: hw/rtl/ptts_pkg.sv
`timescale 1ns / 1ps

package ptts_pkg;

  // Configuration register indexes and widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'd1;

  // Scheduling policies
  localparam logic [1:0] ALG_EDF  = 2'd0;
  localparam logic [1:0] ALG_RMS  = 2'd1;
  localparam logic [1:0] ALG_FCFS = 2'd2;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  // One task table entry, stored as a single memory word
  typedef struct packed {
    logic [15:0] budget_left;
    logic [15:0] period_left;
    logic [15:0] budget_store;
    logic [15:0] period_store;
    logic [15:0] wait_count;
    logic [15:0] job_count;
    logic [7:0]  label;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    budget_left:  16'd0,
    period_left:  16'd0,
    budget_store: 16'd0,
    period_store: 16'd0,
    wait_count:   16'd0,
    job_count:    16'd1,
    label:        8'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK_RD,
    ST_PICK_WR,
    ST_ADV
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_en;
    logic tick_start;
    logic rd_issue;
    logic rd_sel_pick;
    logic cnt_clr;
    logic scan_cmp;
    logic pick_latch;
    logic pick_commit;
    logic adv_wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
    logic rd_pend;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/ptts_if.sv
`timescale 1ns / 1ps

interface ptts_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  task_index;
  logic [7:0]  task_label;
  logic [15:0] exec_budget;
  logic [15:0] period_length;

  modport source (
    output valid, opcode, task_index, task_label, exec_budget, period_length,
    input  ready
  );
  modport sink (
    input  valid, opcode, task_index, task_label, exec_budget, period_length,
    output ready
  );
endinterface

interface ptts_rsp_if;
  logic        valid;
  logic        ready;
  logic        ran_idle;
  logic [2:0]  ran_task;
  logic [7:0]  ran_label;
  logic [15:0] job_number;
  logic        job_done;

  modport source (
    output valid, ran_idle, ran_task, ran_label, job_number, job_done,
    input  ready
  );
  modport sink (
    input  valid, ran_idle, ran_task, ran_label, job_number, job_done,
    output ready
  );
endinterface

interface ptts_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [3:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hw/rtl/ptts_ctrl.sv
`timescale 1ns / 1ps

module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_opcode_i,
  output logic req_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_opcode_i == OP_LOAD) begin
            cmd_o.load_en = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
            cmd_o.cnt_clr    = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_issue = sts_i.more;
        cmd_o.scan_cmp = 1'b1;
        if (!sts_i.more && !sts_i.rd_pend) begin
          state_d = ST_PICK_RD;
        end
      end
      ST_PICK_RD: begin
        // fetch the chosen entry and rewind the counter for the advance pass
        cmd_o.pick_latch  = 1'b1;
        cmd_o.rd_issue    = 1'b1;
        cmd_o.rd_sel_pick = 1'b1;
        cmd_o.cnt_clr     = 1'b1;
        state_d           = ST_PICK_WR;
      end
      ST_PICK_WR: begin
        // hold until the result slot is free
        if (sts_i.out_free) begin
          cmd_o.pick_commit = 1'b1;
          state_d           = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.rd_issue = sts_i.more;
        cmd_o.adv_wr   = 1'b1;
        if (!sts_i.more && !sts_i.rd_pend) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/ptts_dp.sv
`timescale 1ns / 1ps

module ptts_dp
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [2:0]            task_index_i,
  input  logic [7:0]            task_label_i,
  input  logic [15:0]           exec_budget_i,
  input  logic [15:0]           period_length_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic                  ran_idle_o,
  output logic [2:0]            ran_task_o,
  output logic [7:0]            ran_label_o,
  output logic [15:0]           job_number_o,
  output logic                  job_done_o
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  // configuration
  logic [1:0] alg_q;
  logic [3:0] tcount_q;
  logic [CW-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q    <= ALG_EDF;
      tcount_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALGORITHM:  alg_q    <= cfg_data_i[1:0];
        CFG_TASK_COUNT: tcount_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (tcount_q >= MAX_TASKS) ? CW'(MAX_TASKS) : CW'(tcount_q);

  // task table
  entry_t                 mem_q [MAX_TASKS];
  logic [MAX_TASKS-1:0]   ent_vld_q;
  logic [MAX_TASKS-1:0]   active_q;

  logic [CW-1:0] cnt_q;
  logic          more;
  logic [AW-1:0] rd_addr;
  entry_t        rd_q;
  logic          rd_ent_vld_q;
  logic          rd_pend_q;
  logic [AW-1:0] rd_idx_q;
  entry_t        eff;

  logic          best_vld_q;
  logic [AW-1:0] best_idx_q;
  logic [15:0]   best_key_q;
  logic [15:0]   key_v;
  logic          better;

  logic          cur_vld_q;
  logic [AW-1:0] cur_idx_q;
  logic          keep;
  logic          pick_vld_d, pick_vld_q;
  logic [AW-1:0] pick_idx_d, pick_idx_q;

  logic          load_ok;
  logic [AW-1:0] load_addr;
  entry_t        load_ent;
  logic          done;
  entry_t        spent_ent;
  logic          reload;
  entry_t        adv_ent;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic          rsp_valid_q;

  assign more    = cnt_q < n_eff;
  assign rd_addr = cmd_i.rd_sel_pick ? pick_idx_d : cnt_q[AW-1:0];
  assign eff     = rd_ent_vld_q ? rd_q : ENTRY_RST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_issue && !cmd_i.rd_sel_pick) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_q         <= mem_q[rd_addr];
      rd_ent_vld_q <= ent_vld_q[rd_addr];
      rd_idx_q     <= rd_addr;
    end
  end

  // selection scan
  always_comb begin
    case (alg_q)
      ALG_EDF: key_v = eff.period_left;
      ALG_RMS: key_v = eff.period_store;
      default: key_v = eff.wait_count;
    endcase
    if (!best_vld_q) begin
      better = 1'b1;
    end else if (alg_q == ALG_FCFS) begin
      better = key_v > best_key_q;
    end else begin
      better = key_v < best_key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      best_idx_q <= '0;
      best_key_q <= '0;
    end else if (cmd_i.tick_start) begin
      best_vld_q <= 1'b0;
    end else if (cmd_i.scan_cmp && rd_pend_q && active_q[rd_idx_q] && better) begin
      best_vld_q <= 1'b1;
      best_idx_q <= rd_idx_q;
      best_key_q <= key_v;
    end
  end

  // rate monotonic keeps the running task while it is still eligible
  assign keep = (alg_q == ALG_RMS) && cur_vld_q && (cur_idx_q < n_eff) &&
                active_q[cur_idx_q];
  assign pick_vld_d = keep ||
                      (((alg_q == ALG_EDF) || (alg_q == ALG_RMS) ||
                        (alg_q == ALG_FCFS)) && best_vld_q);
  assign pick_idx_d = keep ? cur_idx_q : best_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_vld_q <= 1'b0;
      pick_idx_q <= '0;
    end else if (cmd_i.pick_latch) begin
      pick_vld_q <= pick_vld_d;
      pick_idx_q <= pick_idx_d;
    end
  end

  // entry updates
  assign load_ok   = task_index_i < MAX_TASKS;
  assign load_addr = AW'(task_index_i);

  always_comb begin
    load_ent              = ENTRY_RST;
    load_ent.budget_left  = exec_budget_i;
    load_ent.period_left  = period_length_i;
    load_ent.budget_store = exec_budget_i;
    load_ent.period_store = period_length_i;
    load_ent.label        = task_label_i;
  end

  assign done = eff.budget_left <= 16'd1;

  always_comb begin
    spent_ent             = eff;
    spent_ent.budget_left = done ? 16'd0 : eff.budget_left - 16'd1;
    if (done) begin
      spent_ent.job_count = eff.job_count + 16'd1;
    end
  end

  assign reload = eff.period_left <= 16'd1;

  always_comb begin
    adv_ent = eff;
    if (eff.wait_count != WAIT_MAX) begin
      adv_ent.wait_count = eff.wait_count + 16'd1;
    end
    if (reload) begin
      adv_ent.period_left = eff.period_store;
      adv_ent.budget_left = eff.budget_store;
      adv_ent.wait_count  = 16'd0;
    end else begin
      adv_ent.period_left = eff.period_left - 16'd1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = ENTRY_RST;
    if (cmd_i.load_en && load_ok) begin
      wr_en   = 1'b1;
      wr_addr = load_addr;
      wr_data = load_ent;
    end else if (cmd_i.pick_commit && pick_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = pick_idx_q;
      wr_data = spent_ent;
    end else if (cmd_i.adv_wr && rd_pend_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q;
      wr_data = adv_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      active_q  <= '0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.load_en && load_ok) begin
        active_q[load_addr] <= 1'b1;
      end else if (cmd_i.pick_commit && pick_vld_q && done) begin
        active_q[pick_idx_q] <= 1'b0;
      end else if (cmd_i.adv_wr && rd_pend_q && reload) begin
        active_q[rd_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      cur_idx_q <= '0;
    end else if (cmd_i.pick_commit) begin
      cur_vld_q <= pick_vld_q;
      if (pick_vld_q) begin
        cur_idx_q <= pick_idx_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.pick_commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_commit) begin
      ran_idle_o   <= !pick_vld_q;
      ran_task_o   <= pick_vld_q ? 3'(pick_idx_q) : 3'd0;
      ran_label_o  <= pick_vld_q ? eff.label : 8'd0;
      job_number_o <= pick_vld_q ? eff.job_count : 16'd0;
      job_done_o   <= pick_vld_q && done;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign sts_o.more     = more;
  assign sts_o.rd_pend  = rd_pend_q;
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  // never overwrite a result that is still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick_commit |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result overwritten while pending");

  // a scanned winner is still eligible when the pick is taken
  a_best_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick_latch && best_vld_q && !keep) |-> active_q[best_idx_q])
    else $error("selected task is not active");

  // a finished job retires its entry
  a_done_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick_commit && pick_vld_q && done) |=> !active_q[$past(pick_idx_q)])
    else $error("finished task still active");

  // every scan and advance read stays inside the participating range
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && (cmd_i.scan_cmp || cmd_i.adv_wr)) |-> (rd_idx_q < n_eff))
    else $error("table read beyond task count");

endmodule

// File: hw/rtl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// Load request: writes the table entry if the index fits, no result; the next request is taken the cycle after.
// Tick request, n = min(task_count, MAX_TASKS): the selection scan reads n entries, the pick
// is fetched and committed to the result register, then the advance pass reads n entries and
// the block is ready again. A result still waiting at commit holds the commit until it is taken.
// The scan and the advance pass each do one table read per cycle.
// Reset (rst_ni, async, active low) clears policy, count, active marks and entry valid bits.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  ptts_cfg_if.sink   cfg_i,
  ptts_req_if.sink   req_i,
  ptts_rsp_if.source rsp_o
);

  // Controller sequences a tick as scan, fetch pick, commit result, advance.
  // Datapath holds the task table, the running minimum/maximum and the
  // result register.
  cmd_t cmd;
  sts_t sts;

  // Configuration must be written only while idle; the block itself does not enforce this, so always take it.
  assign cfg_i.ready = 1'b1;

  ptts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  ptts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .task_index_i    (req_i.task_index),
    .task_label_i    (req_i.task_label),
    .exec_budget_i   (req_i.exec_budget),
    .period_length_i (req_i.period_length),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .ran_idle_o      (rsp_o.ran_idle),
    .ran_task_o      (rsp_o.ran_task),
    .ran_label_o     (rsp_o.ran_label),
    .job_number_o    (rsp_o.job_number),
    .job_done_o      (rsp_o.job_done)
  );

endmodule
